>>> hw/rtl/mono_framebuffer_draw_engine_defines.svh
// assertion macros for the draw engine
`ifndef MONO_FRAMEBUFFER_DRAW_ENGINE_DEFINES_SVH
`define MONO_FRAMEBUFFER_DRAW_ENGINE_DEFINES_SVH

// implication checked on the same edge
`define MFB_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// implication checked on the following edge
`define MFB_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> hw/rtl/mfb_pkg.sv
// shared types and constants of the draw engine
package mfb_pkg;

  localparam int CW = 18;

  localparam logic [3:0] MODE_CLEAR     = 4'd0;
  localparam logic [3:0] MODE_SET_PT    = 4'd1;
  localparam logic [3:0] MODE_CLR_PT    = 4'd2;
  localparam logic [3:0] MODE_READ_PT   = 4'd3;
  localparam logic [3:0] MODE_LINE_SET  = 4'd4;
  localparam logic [3:0] MODE_LINE_CLR  = 4'd5;
  localparam logic [3:0] MODE_RECT_SET  = 4'd6;
  localparam logic [3:0] MODE_FILL_SET  = 4'd7;
  localparam logic [3:0] MODE_RECT_CLR  = 4'd8;
  localparam logic [3:0] MODE_FILL_CLR  = 4'd9;
  localparam logic [3:0] MODE_INVERT    = 4'd10;
  localparam logic [3:0] MODE_READ_BYTE = 4'd11;

  localparam logic [7:0] BIT_ONE  = 8'h01;
  localparam logic [2:0] ROW_MASK = 3'h7;

  typedef enum logic {
    WALK_LINE,
    WALK_FILL
  } walk_kind_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CLEAR,
    ST_SEG_LOAD,
    ST_PIX_RD,
    ST_PIX_WR,
    ST_BYTE_RD,
    ST_BYTE_WAIT,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic [3:0]         mode;
    logic signed [15:0] x_start;
    logic signed [15:0] y_start;
    logic signed [15:0] x_end;
    logic signed [15:0] y_end;
  } in_t;

  typedef struct packed {
    logic       pixel_bit;
    logic [7:0] page_byte;
  } out_t;

  typedef struct packed {
    walk_kind_t         kind;
    logic signed [15:0] x1;
    logic signed [15:0] y1;
    logic signed [15:0] x2;
    logic signed [15:0] y2;
  } seg_t;

endpackage

>>> hw/rtl/mfb_store.sv
// frame store memory, one write and one registered read port
module mfb_store #(
  parameter int DEPTH = 1024,
  parameter int AW    = 10
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic [7:0]    wdata,
  input  logic [AW-1:0] raddr,
  output logic [7:0]    rdata
);

  logic [7:0] mem [DEPTH];
  logic [7:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

>>> hw/rtl/mfb_walker.sv
// pixel coordinate walker: bresenham line steps and clipped region scan
module mfb_walker #(
  parameter int COLUMNS = 128,
  parameter int ROWS    = 64
) (
  input  logic                        clk,
  input  logic                        load,
  input  mfb_pkg::seg_t               seg,
  input  logic                        adv,
  output logic signed [mfb_pkg::CW-1:0] px,
  output logic signed [mfb_pkg::CW-1:0] py,
  output logic                        last,
  output logic                        empty
);

  localparam int CW = mfb_pkg::CW;
  localparam int EW = CW + 2;

  mfb_pkg::walk_kind_t kind_r;
  logic signed [CW-1:0] x_r, y_r, xe_r, ye_r, xb_r, adx_r, ady_r;
  logic signed [EW-1:0] err_r;
  logic ux_neg_r, uy_neg_r, xmaj_r, empty_r;

  logic signed [CW-1:0] x1, y1, x2, y2, dx, dy;
  logic signed [CW-1:0] xc1, yc1, xc2, yc2;
  logic signed [CW-1:0] xstep, ystep, minor, major;
  logic signed [EW-1:0] err_s;
  logic                 minor_step;

  always_comb begin
    x1 = CW'(seg.x1);
    y1 = CW'(seg.y1);
    x2 = CW'(seg.x2);
    y2 = CW'(seg.y2);
    dx = x2 - x1;
    dy = y2 - y1;
    xc1 = (x1 < 0) ? '0 : x1;
    yc1 = (y1 < 0) ? '0 : y1;
    xc2 = (x2 > CW'(COLUMNS - 1)) ? CW'(COLUMNS - 1) : x2;
    yc2 = (y2 > CW'(ROWS - 1)) ? CW'(ROWS - 1) : y2;
    xstep = ux_neg_r ? x_r - CW'(1) : x_r + CW'(1);
    ystep = uy_neg_r ? y_r - CW'(1) : y_r + CW'(1);
    minor = xmaj_r ? ady_r : adx_r;
    major = xmaj_r ? adx_r : ady_r;
    err_s = err_r + EW'(minor);
    minor_step = (err_s <<< 1) >= EW'(major);
  end

  always_ff @(posedge clk) begin
    if (load) begin
      kind_r <= seg.kind;
      err_r  <= '0;
      ux_neg_r <= !(dx > 0);
      uy_neg_r <= !(dy > 0);
      adx_r  <= (dx < 0) ? -dx : dx;
      ady_r  <= (dy < 0) ? -dy : dy;
      xmaj_r <= ((dx < 0) ? -dx : dx) > ((dy < 0) ? -dy : dy);
      if (seg.kind == mfb_pkg::WALK_FILL) begin
        x_r  <= xc1;
        xb_r <= xc1;
        y_r  <= yc1;
        xe_r <= xc2;
        ye_r <= yc2;
        empty_r <= (xc1 > xc2) || (yc1 > yc2);
      end else begin
        x_r  <= x1;
        xb_r <= x1;
        y_r  <= y1;
        xe_r <= x2;
        ye_r <= y2;
        empty_r <= 1'b0;
      end
    end else if (adv) begin
      if (kind_r == mfb_pkg::WALK_FILL) begin
        if (x_r == xe_r) begin
          x_r <= xb_r;
          y_r <= y_r + CW'(1);
        end else begin
          x_r <= x_r + CW'(1);
        end
      end else begin
        err_r <= minor_step ? err_s - EW'(major) : err_s;
        if (xmaj_r) begin
          x_r <= xstep;
          if (minor_step) y_r <= ystep;
        end else begin
          y_r <= ystep;
          if (minor_step) x_r <= xstep;
        end
      end
    end
  end

  always_comb begin
    px = x_r;
    py = y_r;
    empty = empty_r;
    if (kind_r == mfb_pkg::WALK_FILL) begin
      last = empty_r || ((x_r == xe_r) && (y_r == ye_r));
    end else begin
      last = xmaj_r ? (x_r == xe_r) : (y_r == ye_r);
    end
  end

endmodule

>>> hw/rtl/mono_framebuffer_draw_engine.sv
// top level of the monochrome page framebuffer draw engine
// each walked pixel is a store read, then a write, as the frame store read is registered;
// a walker load comes before each segment; byte read is ST_BYTE_RD then ST_BYTE_WAIT
// clear screen sweeps the store one byte a cycle: COLUMNS*ceil(ROWS/8) bytes (1024 default)
// one command at a time, busy stays high until the result strobe
// after reset the same clearing pass runs with busy high and gives no result
// the result strobe lasts one cycle and cannot be stalled
`include "mono_framebuffer_draw_engine_defines.svh"

module mono_framebuffer_draw_engine #(
  parameter int COLUMNS = 128,
  parameter int ROWS    = 64
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          start,
  output logic          busy,
  input  mfb_pkg::in_t  in_data,
  output logic          out_valid,
  output mfb_pkg::out_t out_data
);

  localparam int CW    = mfb_pkg::CW;
  localparam int PAGES = (ROWS + 7) / 8;
  localparam int DEPTH = COLUMNS * PAGES;
  localparam int AW    = $clog2(DEPTH);

  mfb_pkg::state_t state_r, state_nxt;
  mfb_pkg::in_t    cmd_r;
  logic [1:0]      seg_r;
  logic [AW-1:0]   clr_cnt_r;
  logic            clr_reply_r;
  logic            pix_r;
  logic [7:0]      byte_r;

  // store ports
  logic          we;
  logic [AW-1:0] waddr, raddr;
  logic [7:0]    wdata, rdata;

  // walker
  logic                 w_load, w_adv, w_last, w_empty;
  mfb_pkg::seg_t        seg;
  logic signed [CW-1:0] px, py;

  logic          on_screen, byte_ok, is_outline, is_read_pt, seg_done;
  logic [AW-1:0] pix_addr, byte_addr;
  logic [7:0]    mask;

  mfb_store #(.DEPTH(DEPTH), .AW(AW)) u_store (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .raddr (raddr),
    .rdata (rdata)
  );

  mfb_walker #(.COLUMNS(COLUMNS), .ROWS(ROWS)) u_walker (
    .clk   (clk),
    .load  (w_load),
    .seg   (seg),
    .adv   (w_adv),
    .px    (px),
    .py    (py),
    .last  (w_last),
    .empty (w_empty)
  );

  // pixel address and bit within its page byte
  always_comb begin
    on_screen = (px >= 0) && (py >= 0) && (px < CW'(COLUMNS)) && (py < CW'(ROWS));
    pix_addr  = AW'($unsigned(px)) + AW'(COLUMNS) * AW'($unsigned(py) >> 3);
    mask      = mfb_pkg::BIT_ONE << (py[2:0] & mfb_pkg::ROW_MASK);
    byte_ok   = (cmd_r.x_start >= 0) && (32'(cmd_r.x_start) < COLUMNS)
             && (cmd_r.y_start >= 0) && (32'(cmd_r.y_start) < PAGES);
    byte_addr = AW'($unsigned(cmd_r.x_start))
              + AW'(COLUMNS) * AW'($unsigned(cmd_r.y_start));
    is_outline = (cmd_r.mode == mfb_pkg::MODE_RECT_SET)
              || (cmd_r.mode == mfb_pkg::MODE_RECT_CLR);
    is_read_pt = (cmd_r.mode == mfb_pkg::MODE_READ_PT);
    seg_done   = !is_outline || (seg_r == 2'd3);
  end

  // segment for the walker: outline sides, a line, a single point or a region
  always_comb begin
    seg.kind = mfb_pkg::WALK_LINE;
    seg.x1 = cmd_r.x_start;
    seg.y1 = cmd_r.y_start;
    seg.x2 = cmd_r.x_end;
    seg.y2 = cmd_r.y_end;
    case (cmd_r.mode) inside
      mfb_pkg::MODE_SET_PT, mfb_pkg::MODE_CLR_PT, mfb_pkg::MODE_READ_PT: begin
        seg.x2 = cmd_r.x_start;
        seg.y2 = cmd_r.y_start;
      end
      mfb_pkg::MODE_RECT_SET, mfb_pkg::MODE_RECT_CLR: begin
        case (seg_r)
          2'd0: seg.y2 = cmd_r.y_start;
          2'd1: seg.y1 = cmd_r.y_end;
          2'd2: seg.x2 = cmd_r.x_start;
          default: seg.x1 = cmd_r.x_end;
        endcase
      end
      mfb_pkg::MODE_FILL_SET, mfb_pkg::MODE_FILL_CLR, mfb_pkg::MODE_INVERT: begin
        seg.kind = mfb_pkg::WALK_FILL;
      end
      default: begin
      end
    endcase
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      mfb_pkg::ST_IDLE: begin
        if (start) begin
          case (in_data.mode) inside
            mfb_pkg::MODE_CLEAR:     state_nxt = mfb_pkg::ST_CLEAR;
            [mfb_pkg::MODE_SET_PT:mfb_pkg::MODE_INVERT]:
                                     state_nxt = mfb_pkg::ST_SEG_LOAD;
            mfb_pkg::MODE_READ_BYTE: state_nxt = mfb_pkg::ST_BYTE_RD;
            default:                 state_nxt = mfb_pkg::ST_DONE;
          endcase
        end
      end
      mfb_pkg::ST_CLEAR: begin
        if (clr_cnt_r == AW'(DEPTH - 1)) begin
          state_nxt = clr_reply_r ? mfb_pkg::ST_DONE : mfb_pkg::ST_IDLE;
        end
      end
      mfb_pkg::ST_SEG_LOAD: state_nxt = mfb_pkg::ST_PIX_RD;
      mfb_pkg::ST_PIX_RD:   state_nxt = mfb_pkg::ST_PIX_WR;
      mfb_pkg::ST_PIX_WR: begin
        if (!w_last) begin
          state_nxt = mfb_pkg::ST_PIX_RD;
        end else if (seg_done) begin
          state_nxt = mfb_pkg::ST_DONE;
        end else begin
          state_nxt = mfb_pkg::ST_SEG_LOAD;
        end
      end
      mfb_pkg::ST_BYTE_RD:   state_nxt = mfb_pkg::ST_BYTE_WAIT;
      mfb_pkg::ST_BYTE_WAIT: state_nxt = mfb_pkg::ST_DONE;
      mfb_pkg::ST_DONE:      state_nxt = mfb_pkg::ST_IDLE;
      default:               state_nxt = mfb_pkg::ST_IDLE;
    endcase
  end

  // outputs and store / walker controls
  always_comb begin
    busy      = (state_r != mfb_pkg::ST_IDLE);
    out_valid = (state_r == mfb_pkg::ST_DONE);
    out_data.pixel_bit = pix_r;
    out_data.page_byte = byte_r;
    we     = 1'b0;
    waddr  = pix_addr;
    wdata  = rdata;
    raddr  = pix_addr;
    w_load = 1'b0;
    w_adv  = 1'b0;
    case (state_r)
      mfb_pkg::ST_CLEAR: begin
        we    = 1'b1;
        waddr = clr_cnt_r;
        wdata = '0;
      end
      mfb_pkg::ST_SEG_LOAD: w_load = 1'b1;
      mfb_pkg::ST_PIX_WR: begin
        // read-modify-write of the byte read in the previous cycle
        we    = on_screen && !w_empty && !is_read_pt;
        w_adv = !w_last;
        case (cmd_r.mode) inside
          mfb_pkg::MODE_SET_PT, mfb_pkg::MODE_LINE_SET, mfb_pkg::MODE_RECT_SET,
          mfb_pkg::MODE_FILL_SET: wdata = rdata | mask;
          mfb_pkg::MODE_INVERT:   wdata = rdata ^ mask;
          default:                wdata = rdata & ~mask;
        endcase
      end
      mfb_pkg::ST_BYTE_RD: raddr = byte_addr;
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= mfb_pkg::ST_CLEAR;
      clr_cnt_r   <= '0;
      clr_reply_r <= 1'b0;
      seg_r       <= '0;
    end else begin
      state_r <= state_nxt;
      if (state_r == mfb_pkg::ST_IDLE && start) begin
        clr_cnt_r   <= '0;
        clr_reply_r <= 1'b1;
        seg_r       <= '0;
      end
      if (state_r == mfb_pkg::ST_CLEAR) begin
        clr_cnt_r <= clr_cnt_r + AW'(1);
      end
      if (state_r == mfb_pkg::ST_PIX_WR && w_last && !seg_done) begin
        seg_r <= seg_r + 2'd1;
      end
    end
  end

  // command and result payload
  always_ff @(posedge clk) begin
    if (state_r == mfb_pkg::ST_IDLE && start) begin
      cmd_r  <= in_data;
      pix_r  <= 1'b0;
      byte_r <= '0;
    end
    if (state_r == mfb_pkg::ST_PIX_WR && is_read_pt) begin
      pix_r <= on_screen && rdata[py[2:0]];
    end
    if (state_r == mfb_pkg::ST_BYTE_WAIT) begin
      byte_r <= byte_ok ? rdata : 8'h00;
    end
  end

  `MFB_ASSERT_NEXT(a_single_strobe, out_valid, !out_valid, "result strobe longer than a cycle")
  `MFB_ASSERT_NEXT(a_busy_after_start, start && !busy, busy, "not busy after command transfer")
  `MFB_ASSERT_SAME(a_no_write_idle, !busy, !we, "store written while idle")

endmodule

>>> test/tb_mono_framebuffer_draw_engine.sv
// testbench for the monochrome page framebuffer draw engine
`timescale 1ns / 100ps

// predicts each command on a private framebuffer image and checks the results
class draw_scoreboard;
  localparam int COLS = 128;
  localparam int ROWS = 64;
  localparam int PAGES = (ROWS + 7) / 8;

  typedef enum int {
    PIX_SET,
    PIX_CLR,
    PIX_INV
  } pix_op_t;

  logic [7:0] image[COLS * PAGES];
  mfb_pkg::out_t pending[$];
  int mismatches;
  int checked;

  function void wipe();
    foreach (image[i]) image[i] = 8'h00;
  endfunction

  function bit visible(int x, int y);
    return x >= 0 && y >= 0 && x < COLS && y < ROWS;
  endfunction

  function void touch(int x, int y, pix_op_t op);
    int a;
    logic [7:0] m;
    if (!visible(x, y)) return;
    a = x + COLS * (y >> 3);
    m = mfb_pkg::BIT_ONE << (y & int'(mfb_pkg::ROW_MASK));
    case (op)
      PIX_SET: image[a] = image[a] | m;
      PIX_CLR: image[a] = image[a] & ~m;
      default: image[a] = image[a] ^ m;
    endcase
  endfunction

  // bresenham walk, both ends plotted, x major only when strictly longer
  function void walk_line(int x1, int y1, int x2, int y2, pix_op_t op);
    int dx, dy, ux, uy, adx, ady, x, y, acc;
    dx = x2 - x1;
    dy = y2 - y1;
    ux = dx > 0 ? 1 : -1;
    uy = dy > 0 ? 1 : -1;
    adx = dx < 0 ? -dx : dx;
    ady = dy < 0 ? -dy : dy;
    x = x1;
    y = y1;
    acc = 0;
    if (adx > ady) begin
      for (x = x1; x != x2 + ux; x += ux) begin
        touch(x, y, op);
        acc += ady;
        if (2 * acc >= adx) begin
          y += uy;
          acc -= adx;
        end
      end
    end else begin
      for (y = y1; y != y2 + uy; y += uy) begin
        touch(x, y, op);
        acc += adx;
        if (2 * acc >= ady) begin
          x += ux;
          acc -= ady;
        end
      end
    end
  endfunction

  function void fill_box(int x1, int y1, int x2, int y2, pix_op_t op);
    if (x1 < 0) x1 = 0;
    if (y1 < 0) y1 = 0;
    if (x2 > COLS - 1) x2 = COLS - 1;
    if (y2 > ROWS - 1) y2 = ROWS - 1;
    for (int y = y1; y <= y2; y++)
      for (int x = x1; x <= x2; x++) touch(x, y, op);
  endfunction

  function void frame_box(int x1, int y1, int x2, int y2, pix_op_t op);
    walk_line(x1, y1, x2, y1, op);
    walk_line(x1, y2, x2, y2, op);
    walk_line(x1, y1, x1, y2, op);
    walk_line(x2, y1, x2, y2, op);
  endfunction

  // apply an accepted command and queue its result
  function void note_command(mfb_pkg::in_t c);
    mfb_pkg::out_t r;
    int xs, ys, xe, ye;
    xs = c.x_start;
    ys = c.y_start;
    xe = c.x_end;
    ye = c.y_end;
    r = '0;
    case (c.mode)
      mfb_pkg::MODE_CLEAR: wipe();
      mfb_pkg::MODE_SET_PT: touch(xs, ys, PIX_SET);
      mfb_pkg::MODE_CLR_PT: touch(xs, ys, PIX_CLR);
      mfb_pkg::MODE_READ_PT:
        if (visible(xs, ys)) r.pixel_bit = image[xs + COLS * (ys >> 3)][ys & 7];
      mfb_pkg::MODE_LINE_SET: walk_line(xs, ys, xe, ye, PIX_SET);
      mfb_pkg::MODE_LINE_CLR: walk_line(xs, ys, xe, ye, PIX_CLR);
      mfb_pkg::MODE_RECT_SET: frame_box(xs, ys, xe, ye, PIX_SET);
      mfb_pkg::MODE_FILL_SET: fill_box(xs, ys, xe, ye, PIX_SET);
      mfb_pkg::MODE_RECT_CLR: frame_box(xs, ys, xe, ye, PIX_CLR);
      mfb_pkg::MODE_FILL_CLR: fill_box(xs, ys, xe, ye, PIX_CLR);
      mfb_pkg::MODE_INVERT: fill_box(xs, ys, xe, ye, PIX_INV);
      mfb_pkg::MODE_READ_BYTE:
        if (xs >= 0 && xs < COLS && ys >= 0 && ys < PAGES) r.page_byte = image[xs + COLS * ys];
      default: ;
    endcase
    pending.push_back(r);
  endfunction

  function void check_result(mfb_pkg::out_t got);
    mfb_pkg::out_t want;
    checked++;
    if (pending.size() == 0) begin
      mismatches++;
      if (mismatches <= 10) $display("unexpected result pixel=%0d byte=%02h",
                                     got.pixel_bit, got.page_byte);
      return;
    end
    want = pending.pop_front();
    if (got.pixel_bit !== want.pixel_bit || got.page_byte !== want.page_byte) begin
      mismatches++;
      if (mismatches <= 10)
        $display("result %0d: expected pixel=%0d byte=%02h, got pixel=%0d byte=%02h",
                 checked, want.pixel_bit, want.page_byte, got.pixel_bit, got.page_byte);
    end
  endfunction
endclass

module tb_mono_framebuffer_draw_engine;

  logic clk;
  logic rst_n;
  logic start;
  logic busy;
  mfb_pkg::in_t in_data;
  logic out_valid;
  mfb_pkg::out_t out_data;

  draw_scoreboard board;
  int issued;
  int mode_hits[16];

  mono_framebuffer_draw_engine dut (
    .clk(clk),
    .rst_n(rst_n),
    .start(start),
    .busy(busy),
    .in_data(in_data),
    .out_valid(out_valid),
    .out_data(out_data)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // results cannot be stalled, so every strobe is checked straight away
  always @(posedge clk) begin
    if (rst_n && out_valid) board.check_result(out_data);
  end

  // one command transfer: idle gap, raise start, hold until an edge sees busy low
  // start stays high into the next command when it follows with no gap
  task automatic send_command(mfb_pkg::in_t c);
    int gap;
    gap = $urandom_range(0, 4);
    if ($urandom_range(0, 3) == 0) gap = 0;
    if (gap > 0) begin
      start <= 1'b0;
      in_data <= '0;
      repeat (gap) @(posedge clk);
    end
    start <= 1'b1;
    in_data <= c;
    @(posedge clk);
    while (busy) @(posedge clk);
    // transfer happened at this edge
    board.note_command(c);
    mode_hits[c.mode]++;
    issued++;
  endtask

  task automatic send(logic [3:0] m, int xs, int ys, int xe, int ye);
    mfb_pkg::in_t c;
    c.mode = m;
    c.x_start = 16'(xs);
    c.y_start = 16'(ys);
    c.x_end = 16'(xe);
    c.y_end = 16'(ye);
    send_command(c);
  endtask

  // coordinates mostly near the screen, sometimes anywhere in 16 bits
  function automatic int pick_x();
    case ($urandom_range(0, 9))
      0: return $signed(16'($urandom));
      1: return $urandom_range(0, 3) == 0 ? -32768 : 32767;
      default: return int'($urandom_range(0, 143)) - 8;
    endcase
  endfunction

  function automatic int pick_y();
    case ($urandom_range(0, 9))
      0: return $signed(16'($urandom));
      1: return $urandom_range(0, 3) == 0 ? -32768 : 32767;
      default: return int'($urandom_range(0, 79)) - 8;
    endcase
  endfunction

  // line and outline walks stay modest: both ends near the screen, or the far end within 300 of the start
  task automatic random_command();
    logic [3:0] m;
    int xs, ys, xe, ye;
    m = 4'($urandom_range(0, 15));
    if (m == mfb_pkg::MODE_CLEAR && $urandom_range(0, 7) != 0) m = mfb_pkg::MODE_READ_BYTE;
    xs = pick_x();
    ys = pick_y();
    xe = pick_x();
    ye = pick_y();
    if (m == mfb_pkg::MODE_LINE_SET || m == mfb_pkg::MODE_LINE_CLR
        || m == mfb_pkg::MODE_RECT_SET || m == mfb_pkg::MODE_RECT_CLR) begin
      if ($urandom_range(0, 19) != 0) begin
        xs = int'($urandom_range(0, 143)) - 8;
        ys = int'($urandom_range(0, 79)) - 8;
        xe = int'($urandom_range(0, 143)) - 8;
        ye = int'($urandom_range(0, 79)) - 8;
      end else begin
        // a far end still walks a bounded number of pixels on one axis
        xe = xs + int'($urandom_range(0, 600)) - 300;
        ye = ys + int'($urandom_range(0, 600)) - 300;
        xe = xe > 32767 ? 32767 : (xe < -32768 ? -32768 : xe);
        ye = ye > 32767 ? 32767 : (ye < -32768 ? -32768 : ye);
      end
    end
    if (m == mfb_pkg::MODE_READ_BYTE && $urandom_range(0, 3) != 0) begin
      xs = $urandom_range(0, 127);
      ys = $urandom_range(0, 7);
    end
    if (m == mfb_pkg::MODE_READ_PT && $urandom_range(0, 3) != 0) begin
      xs = $urandom_range(0, 127);
      ys = $urandom_range(0, 63);
    end
    send(m, xs, ys, xe, ye);
  endtask

  initial begin
    int settle;
    board = new();
    board.wipe();
    issued = 0;
    rst_n = 1'b0;
    start = 1'b0;
    in_data = '0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    // directed: every mode, screen corners, clipping and degenerate shapes
    send(mfb_pkg::MODE_READ_BYTE, 0, 0, 0, 0);
    send(mfb_pkg::MODE_SET_PT, 0, 0, 0, 0);
    send(mfb_pkg::MODE_SET_PT, 127, 63, 0, 0);
    send(mfb_pkg::MODE_SET_PT, 128, 64, 0, 0);
    send(mfb_pkg::MODE_READ_PT, 127, 63, 0, 0);
    send(mfb_pkg::MODE_READ_PT, -1, 0, 0, 0);
    send(mfb_pkg::MODE_CLR_PT, 0, 0, 0, 0);
    send(mfb_pkg::MODE_LINE_SET, -10, -5, 140, 70);
    send(mfb_pkg::MODE_LINE_SET, 20, 20, 20, 20);
    send(mfb_pkg::MODE_LINE_CLR, 100, 10, 5, 50);
    send(mfb_pkg::MODE_LINE_SET, 0, 0, 40, 40);
    send(mfb_pkg::MODE_RECT_SET, 10, 10, 60, 30);
    send(mfb_pkg::MODE_RECT_CLR, 60, 30, 10, 10);
    send(mfb_pkg::MODE_FILL_SET, -32768, -32768, 32767, 32767);
    send(mfb_pkg::MODE_FILL_CLR, 5, 5, 70, 40);
    send(mfb_pkg::MODE_FILL_SET, 30, 30, 20, 20);
    send(mfb_pkg::MODE_INVERT, -20, -20, 200, 100);
    send(mfb_pkg::MODE_INVERT, 50, 50, 40, 60);
    send(mfb_pkg::MODE_READ_BYTE, 127, 7, 0, 0);
    send(mfb_pkg::MODE_READ_BYTE, 128, 0, 0, 0);
    send(mfb_pkg::MODE_READ_BYTE, 0, 8, 0, 0);
    send(4'd12, 1, 1, 1, 1);
    send(4'd15, -1, -1, -1, -1);
    send(mfb_pkg::MODE_CLEAR, 0, 0, 0, 0);
    send(mfb_pkg::MODE_READ_BYTE, 10, 2, 0, 0);

    repeat (1025) random_command();
    start <= 1'b0;
    in_data <= '0;

    settle = 0;
    while (board.pending.size() != 0 && settle < 200000) begin
      @(posedge clk);
      settle++;
    end
    repeat (20) @(posedge clk);

    $display("%0d commands issued, %0d results checked", issued, board.checked);
    $display("reads: %0d point, %0d byte; fills/inverts: %0d",
             mode_hits[mfb_pkg::MODE_READ_PT], mode_hits[mfb_pkg::MODE_READ_BYTE],
             mode_hits[mfb_pkg::MODE_FILL_SET] + mode_hits[mfb_pkg::MODE_FILL_CLR]
             + mode_hits[mfb_pkg::MODE_INVERT]);
    if (board.mismatches == 0 && board.pending.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

  // a full-screen fill is the longest command; even 1050 of those fit
  initial begin
    #200000000;
    $display("Verification failed");
    $finish;
  end
endmodule
